// File: sv/ffha_pkg.sv
package ffha_pkg;

	localparam int DEF_HEAP_BYTES   = 32768;
	localparam int MIN_BLOCK_BYTES  = 8;
	localparam int WORD_BYTES       = 4;
	localparam logic [15:0] RESET_HEAP_BYTES = 16'd32768;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic REG_HEAP_BASE  = 1'b0;
	localparam logic REG_HEAP_BYTES = 1'b1;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_A_LOOP,
		ST_A_EVAL,
		ST_A_FIN,
		ST_F_SZ,
		ST_F_HEAD,
		ST_F_WALK,
		ST_F_NXT,
		ST_RESP
	} ffha_state_t;

endpackage

// File: sv/ffha_ram.sv
module ffha_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/ffha_ctrl.sv
module ffha_ctrl import ffha_pkg::*; #(
	parameter int HEAP_BYTES = DEF_HEAP_BYTES,
	parameter int WORDS = HEAP_BYTES / WORD_BYTES,
	parameter int AW = $clog2(WORDS),
	parameter int LW = $clog2(WORDS + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_addr,
	input  logic [31:0]   cfg_wdata,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          op,
	input  logic [15:0]   request_bytes,
	input  logic [31:0]   free_handle,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [31:0]   result_handle,
	output logic [15:0]   granted_bytes,
	output logic          ok,
	output logic [15:0]   free_bytes,
	output logic [AW-1:0] rd_addr,
	input  logic [LW-1:0] lnk_rdata,
	input  logic [15:0]   sz_rdata,
	output logic          lnk_we,
	output logic [AW-1:0] lnk_waddr,
	output logic [LW-1:0] lnk_wdata,
	output logic          sz_we,
	output logic [AW-1:0] sz_waddr,
	output logic [15:0]   sz_wdata
);

	localparam int CW = ((LW > 16) ? LW : 16) + 1;
	localparam logic [LW-1:0] LINK_END = LW'(WORDS);

	ffha_state_t state_q, state_d;
	logic [31:0] base_q;
	logic [15:0] bytes_q;
	logic [LW-1:0] head_q, head_d, cur_q, cur_d, prev_q, prev_d, nxt_q, nxt_d;
	logic [LW-1:0] fw_q, fw_d, split_q, split_d;
	logic [14:0] steps_q, steps_d;
	logic [16:0] need_q, need_d;
	logic [15:0] sz_q, sz_d, csz_q, csz_d, grant_q, grant_d, ssz_q, ssz_d;
	logic dosplit_q, dosplit_d;
	logic [15:0] fcount_q, fcount_d;
	logic [31:0] rh_q, rh_d;
	logic [15:0] rg_q, rg_d;
	logic rok_q, rok_d;
	logic ov_q;
	logic [31:0] oh_q;
	logic [15:0] og_q, of_q;
	logic ook_q;
	logic load_out;

	logic [15:0] hlen;
	logic [CW-1:0] n_c;
	logic [LW-1:0] head_w, lk;
	logic [31:0] off;
	logic [LW-1:0] in_fw;
	logic [16:0] in_need, rem;
	logic [CW-1:0] split_c, cur_end;

	always_comb begin
		hlen = bytes_q & 16'hFFFC;
		if (hlen < 16'(MIN_BLOCK_BYTES)) hlen = 16'(MIN_BLOCK_BYTES);
		if (32'(hlen) > 32'(HEAP_BYTES)) hlen = 16'(HEAP_BYTES);
	end

	assign n_c    = CW'(hlen[15:2]);
	assign head_w = (CW'(head_q) < n_c) ? head_q : LINK_END;
	assign lk     = (CW'(lnk_rdata) < n_c) ? lnk_rdata : LINK_END;
	assign off    = free_handle - base_q - 32'd4;
	assign in_fw  = LW'(off[15:2]);
	assign in_need = ((17'(request_bytes) + 17'd7) & ~17'd3) < 17'(MIN_BLOCK_BYTES)
		? 17'(MIN_BLOCK_BYTES) : ((17'(request_bytes) + 17'd7) & ~17'd3);
	assign rem     = 17'(sz_rdata) - need_q;
	assign split_c = CW'(cur_q) + CW'(need_q[16:2]);
	assign cur_end = CW'(cur_q) + CW'(sz_rdata[15:2]);

	assign in_ready = (state_q == ST_IDLE);
	assign load_out = !ov_q || out_ready;

	always_comb begin
		state_d = state_q;
		head_d = head_q; cur_d = cur_q; prev_d = prev_q; nxt_d = nxt_q;
		fw_d = fw_q; split_d = split_q; steps_d = steps_q; need_d = need_q;
		sz_d = sz_q; csz_d = csz_q; grant_d = grant_q; ssz_d = ssz_q;
		dosplit_d = dosplit_q; fcount_d = fcount_q;
		rh_d = rh_q; rg_d = rg_q; rok_d = rok_q;
		rd_addr = in_fw[AW-1:0];
		lnk_we = 1'b0; lnk_waddr = '0; lnk_wdata = LINK_END;
		sz_we = 1'b0; sz_waddr = '0; sz_wdata = hlen;
		case (state_q)
			ST_INIT: begin
				lnk_we = 1'b1;
				sz_we = 1'b1;
				head_d = '0;
				fcount_d = hlen;
				state_d = ST_IDLE;
			end
			ST_IDLE: begin
				rh_d = '0; rg_d = '0; rok_d = 1'b0;
				if (in_valid) begin
					if (op == OP_ALLOC) begin
						if (request_bytes == 16'd0) begin
							state_d = ST_RESP;
						end else begin
							need_d = in_need;
							cur_d = head_w;
							prev_d = LINK_END;
							steps_d = '0;
							state_d = ST_A_LOOP;
						end
					end else begin
						fw_d = in_fw;
						if (free_handle == 32'd0 || off[1:0] != 2'd0 || off >= 32'(hlen))
							state_d = ST_RESP;
						else
							state_d = ST_F_SZ;
					end
				end
			end
			ST_A_LOOP: begin
				rd_addr = cur_q[AW-1:0];
				if (cur_q == LINK_END || CW'(steps_q) >= n_c) state_d = ST_RESP;
				else state_d = ST_A_EVAL;
			end
			ST_A_EVAL: begin
				if (17'(sz_rdata) >= need_q) begin
					dosplit_d = (rem >= 17'(MIN_BLOCK_BYTES)) && (split_c < n_c);
					split_d = LW'(split_c);
					ssz_d = rem[15:0];
					grant_d = dosplit_d ? need_q[15:0] : sz_rdata;
					nxt_d = dosplit_d ? LW'(split_c) : lk;
					lnk_we = dosplit_d;
					lnk_waddr = split_c[AW-1:0];
					lnk_wdata = lk;
					sz_we = 1'b1;
					sz_waddr = cur_q[AW-1:0];
					sz_wdata = grant_d;
					state_d = ST_A_FIN;
				end else begin
					prev_d = cur_q;
					cur_d = lk;
					steps_d = steps_q + 15'd1;
					state_d = ST_A_LOOP;
				end
			end
			ST_A_FIN: begin
				sz_we = dosplit_q;
				sz_waddr = split_q[AW-1:0];
				sz_wdata = ssz_q;
				if (prev_q != LINK_END) begin
					lnk_we = 1'b1;
					lnk_waddr = prev_q[AW-1:0];
					lnk_wdata = nxt_q;
				end else begin
					head_d = nxt_q;
				end
				fcount_d = fcount_q - grant_q;
				rh_d = base_q + (32'(cur_q) << 2) + 32'd4;
				rg_d = grant_q;
				rok_d = 1'b1;
				state_d = ST_RESP;
			end
			ST_F_SZ: begin
				if (sz_rdata < 16'(MIN_BLOCK_BYTES) || sz_rdata[1:0] != 2'd0 ||
				    32'(sz_rdata) > 32'(hlen) - off) begin
					state_d = ST_RESP;
				end else begin
					sz_d = sz_rdata;
					fcount_d = fcount_q + sz_rdata;
					rok_d = 1'b1;
					cur_d = head_w;
					steps_d = '0;
					lnk_we = 1'b1;
					lnk_waddr = fw_q[AW-1:0];
					lnk_wdata = LINK_END;
					rd_addr = head_w[AW-1:0];
					if (head_w == LINK_END) begin
						head_d = fw_q;
						state_d = ST_RESP;
					end else if (head_w >= fw_q) begin
						head_d = fw_q;
						if (CW'(fw_q) + CW'(sz_rdata[15:2]) == CW'(head_w)) begin
							state_d = ST_F_HEAD;
						end else begin
							lnk_wdata = head_w;
							state_d = ST_RESP;
						end
					end else begin
						state_d = ST_F_WALK;
					end
				end
			end
			ST_F_HEAD: begin
				lnk_we = 1'b1;
				lnk_waddr = fw_q[AW-1:0];
				lnk_wdata = lk;
				sz_we = 1'b1;
				sz_waddr = fw_q[AW-1:0];
				sz_wdata = sz_q + sz_rdata;
				state_d = ST_RESP;
			end
			ST_F_WALK: begin
				rd_addr = lk[AW-1:0];
				if (lk != LINK_END && lk < fw_q && CW'(steps_q) < n_c) begin
					cur_d = lk;
					steps_d = steps_q + 15'd1;
				end else begin
					nxt_d = lk;
					if (cur_end == CW'(fw_q)) begin
						sz_we = 1'b1;
						sz_waddr = cur_q[AW-1:0];
						sz_wdata = sz_rdata + sz_q;
						csz_d = sz_rdata + sz_q;
					end else begin
						lnk_we = 1'b1;
						lnk_waddr = cur_q[AW-1:0];
						lnk_wdata = fw_q;
						cur_d = fw_q;
						csz_d = sz_q;
					end
					state_d = (lk != LINK_END) ? ST_F_NXT : ST_RESP;
				end
			end
			ST_F_NXT: begin
				lnk_we = 1'b1;
				lnk_waddr = cur_q[AW-1:0];
				sz_waddr = cur_q[AW-1:0];
				sz_wdata = csz_q + sz_rdata;
				if (CW'(cur_q) + CW'(csz_q[15:2]) == CW'(nxt_q)) begin
					sz_we = 1'b1;
					lnk_wdata = lk;
				end else begin
					lnk_wdata = nxt_q;
				end
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (load_out) state_d = ST_IDLE;
			end
			default: state_d = ST_INIT;
		endcase
		// a register write re-initializes the heap
		if (cfg_we) state_d = ST_INIT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			base_q <= '0;
			bytes_q <= RESET_HEAP_BYTES;
			head_q <= '0;
			fcount_q <= '0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q <= head_d;
			fcount_q <= fcount_d;
			if (cfg_we) begin
				if (cfg_addr == REG_HEAP_BASE) base_q <= cfg_wdata;
				else if (cfg_addr == REG_HEAP_BYTES) bytes_q <= cfg_wdata[15:0];
			end
			if (state_q == ST_RESP && load_out) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_d; prev_q <= prev_d; nxt_q <= nxt_d; fw_q <= fw_d;
		split_q <= split_d; steps_q <= steps_d; need_q <= need_d;
		sz_q <= sz_d; csz_q <= csz_d; grant_q <= grant_d; ssz_q <= ssz_d;
		dosplit_q <= dosplit_d;
		rh_q <= rh_d; rg_q <= rg_d; rok_q <= rok_d;
		if (state_q == ST_RESP && load_out) begin
			oh_q <= rh_q;
			og_q <= rg_q;
			ook_q <= rok_q;
			of_q <= fcount_q;
		end
	end

	assign out_valid     = ov_q;
	assign result_handle = oh_q;
	assign granted_bytes = og_q;
	assign ok            = ook_q;
	assign free_bytes    = of_q;

endmodule

// File: sv/first_fit_heap_allocator.sv
// First-fit heap allocator with an address-ordered free list and coalescing.
// Link and size words live in two single-port-read RAMs; each request walks
// the free list one block per RAM read. An allocate checks free blocks in
// order and, on a fit, splits the block if large enough and unlinks it; a
// free checks the released block, walks the free blocks below it and merges
// it with its neighbours. A zero request or a rejected handle goes straight
// to the result stage, which loads the result register when the output is
// free. A register write rebuilds the heap as one free block (also on reset).
module first_fit_heap_allocator import ffha_pkg::*; #(
	parameter int HEAP_BYTES = DEF_HEAP_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [15:0] request_bytes,
	input  logic [31:0] free_handle,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] result_handle,
	output logic [15:0] granted_bytes,
	output logic        ok,
	output logic [15:0] free_bytes
);

	localparam int WORDS = HEAP_BYTES / WORD_BYTES;
	localparam int AW = $clog2(WORDS);
	localparam int LW = $clog2(WORDS + 1);

	logic [AW-1:0] rd_addr, lnk_waddr, sz_waddr;
	logic [LW-1:0] lnk_rdata, lnk_wdata;
	logic [15:0] sz_rdata, sz_wdata;
	logic lnk_we, sz_we;

	ffha_ram #(.WIDTH(LW), .DEPTH(WORDS)) u_link_ram (
		.clk(clk), .we(lnk_we), .waddr(lnk_waddr), .wdata(lnk_wdata),
		.raddr(rd_addr), .rdata(lnk_rdata)
	);

	ffha_ram #(.WIDTH(16), .DEPTH(WORDS)) u_size_ram (
		.clk(clk), .we(sz_we), .waddr(sz_waddr), .wdata(sz_wdata),
		.raddr(rd_addr), .rdata(sz_rdata)
	);

	ffha_ctrl #(.HEAP_BYTES(HEAP_BYTES)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .op(op),
		.request_bytes(request_bytes), .free_handle(free_handle),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_handle(result_handle), .granted_bytes(granted_bytes),
		.ok(ok), .free_bytes(free_bytes),
		.rd_addr(rd_addr), .lnk_rdata(lnk_rdata), .sz_rdata(sz_rdata),
		.lnk_we(lnk_we), .lnk_waddr(lnk_waddr), .lnk_wdata(lnk_wdata),
		.sz_we(sz_we), .sz_waddr(sz_waddr), .sz_wdata(sz_wdata)
	);

endmodule
